// File: rtl/core/pedal_signal_conditioner_macros.svh
// Assertion macros shared by the pedal signal conditioner RTL.
`ifndef PEDAL_SIGNAL_CONDITIONER_MACROS_SVH
`define PEDAL_SIGNAL_CONDITIONER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/psc_pkg.sv
// Package: types, constants and register codes of the pedal signal conditioner.
package psc_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int A_LEVEL_W  = 11;
    localparam int LEVEL_W    = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ON     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_OFF    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_CUT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_REARM = 8'd3;

    localparam logic [LEVEL_W-1:0] BRAKE_ON_RST     = 12'd1850;
    localparam logic [LEVEL_W-1:0] BRAKE_OFF_RST    = 12'd1650;
    localparam logic [LEVEL_W-1:0] TORQUE_CUT_RST   = 12'd813;
    localparam logic [LEVEL_W-1:0] TORQUE_REARM_RST = 12'd215;

    localparam logic [LEVEL_W-1:0] A_MIN       = 12'd866;
    localparam logic [LEVEL_W-1:0] A_MAX       = 12'd1220;
    localparam logic [LEVEL_W-1:0] B_MIN       = 12'd120;
    localparam logic [LEVEL_W-1:0] B_MAX       = 12'd2100;
    localparam logic [LEVEL_W-1:0] BRAKE_MIN   = 12'd1293;
    localparam logic [LEVEL_W-1:0] A_FAULT     = 12'd2500;
    localparam logic [LEVEL_W-1:0] B_FAULT     = 12'd2400;
    localparam logic [LEVEL_W-1:0] BRAKE_FAULT = 12'd2700;

    // mismatch curve in Q16: f(a) = (K2*a - K1)*a + K0
    localparam int Q_SHIFT = 16;
    localparam int QT_W    = 19;   // signed width of K2*a - K1 over the clamp range
    localparam int F_W     = 30;   // f is positive and below 2^29 over the clamp range
    localparam logic [10:0] K2 = 11'd643;
    localparam logic [19:0] K1 = 20'd619774;
    localparam logic [25:0] K0 = 26'd62469734;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_DIV_K,
        ST_QUAD_LIN,
        ST_QUAD_SQ,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        MUL_DIV_A,
        MUL_DIV_B,
        MUL_DIV_K,
        MUL_LIN,
        MUL_SQ
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     cap_a;
        logic     cap_b;
        logic     cap_k;
        logic     finish;
    } t_seq_ctrl;

endpackage

// File: rtl/core/psc_if.sv
// Channel interfaces: sample request, result request and register write.
interface psc_in_if #(
    parameter int ADC_BITS = psc_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] throttle_a_sample;
    logic [ADC_BITS-1:0] throttle_b_sample;
    logic [ADC_BITS-1:0] brake_sample;
    logic                run_permitted;

    modport source (
        output valid, throttle_a_sample, throttle_b_sample, brake_sample, run_permitted,
        input  ready
    );
    modport sink (
        input  valid, throttle_a_sample, throttle_b_sample, brake_sample, run_permitted,
        output ready
    );
endinterface

interface psc_out_if;
    logic                              valid;
    logic                              ready;
    logic [psc_pkg::A_LEVEL_W-1:0]     throttle_a_level;
    logic [psc_pkg::LEVEL_W-1:0]       throttle_b_level;
    logic [psc_pkg::LEVEL_W-1:0]       brake_level;
    logic                              brake_pressed;
    logic                              torque_allowed;
    logic                              torque_cut_now;
    logic                              sensor_fault;
    logic                              sensor_mismatch;

    modport source (
        output valid, throttle_a_level, throttle_b_level, brake_level, brake_pressed,
               torque_allowed, torque_cut_now, sensor_fault, sensor_mismatch,
        input  ready
    );
    modport sink (
        input  valid, throttle_a_level, throttle_b_level, brake_level, brake_pressed,
               torque_allowed, torque_cut_now, sensor_fault, sensor_mismatch,
        output ready
    );
endinterface

interface psc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psc_pkg::CFG_IDX_W-1:0]  index;
    logic [psc_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/core/pedal_signal_conditioner.sv
// Pedal signal conditioner top level: filters, clamps, flags and mismatch check.
// A sample set accepted in ST_IDLE steps through DIV_A, DIV_B, DIV_K, QUAD_LIN and QUAD_SQ
// on the single shared multiplier (three divide-by-6, two quadratic products); ST_FINISH
// registers the result once output is free; then ST_IDLE takes new sets. Reset: synchronous
// i_rst_n clears history and flags but sets torque, loads default levels; no clear pass.
`include "pedal_signal_conditioner_macros.svh"

module pedal_signal_conditioner #(
    parameter int ADC_BITS = psc_pkg::ADC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    psc_in_if.sink    i_in,
    psc_cfg_if.sink   i_cfg,
    psc_out_if.source o_out
);

    localparam int SUM_W  = ADC_BITS + 3;
    localparam int RCP_SH = SUM_W;
    localparam int RCP    = (1 << SUM_W) / 6;
    localparam int RCP_W  = SUM_W - 2;
    localparam int MA_W   = (SUM_W + 1 > psc_pkg::QT_W) ? SUM_W + 1 : psc_pkg::QT_W;
    localparam int MB_W   = (RCP_W + 1 > 12) ? RCP_W + 1 : 12;
    localparam int P_W    = MA_W + MB_W;
    localparam int FW     = (ADC_BITS > psc_pkg::LEVEL_W) ? ADC_BITS : psc_pkg::LEVEL_W;
    localparam int F_W    = psc_pkg::F_W;
    localparam int D10_W  = F_W + 3;

    // configuration
    logic [psc_pkg::LEVEL_W-1:0] r_brake_on;
    logic [psc_pkg::LEVEL_W-1:0] r_brake_off;
    logic [psc_pkg::LEVEL_W-1:0] r_torque_cut;
    logic [psc_pkg::LEVEL_W-1:0] r_torque_rearm;

    // state
    logic [ADC_BITS-1:0] r_ha0, r_ha1, r_hb0, r_hb1, r_hk0, r_hk1;
    logic [psc_pkg::LEVEL_W-1:0] r_last_brake;
    logic r_brake, r_torque, r_fault;

    // working registers
    logic [SUM_W-1:0]    r_sum_a, r_sum_b, r_sum_k;
    logic [ADC_BITS-1:0] r_fa, r_fb, r_fk;
    logic                r_run;

    // result register
    logic                          r_out_valid;
    logic [psc_pkg::A_LEVEL_W-1:0] r_out_a;
    logic [psc_pkg::LEVEL_W-1:0]   r_out_b, r_out_k;
    logic r_out_brake, r_out_torque, r_out_cut, r_out_fault, r_out_mis;

    psc_pkg::t_seq_ctrl ctrl;
    logic               in_ready;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;

    logic [SUM_W-1:0]    sum_a_n, sum_b_n, sum_k_n;
    logic [SUM_W-1:0]    div_sum, rem;
    logic [ADC_BITS-1:0] q0, quo;

    logic [FW-1:0] fa_x, fb_x, fk_x, k_lvl;
    logic [psc_pkg::A_LEVEL_W-1:0] a_clamp;
    logic [psc_pkg::LEVEL_W-1:0]   b_clamp;
    logic signed [psc_pkg::QT_W-1:0] quad_t;

    logic [F_W-1:0]   f_val, d_abs;
    logic [F_W:0]     d_raw;
    logic [D10_W-1:0] d10;
    logic             mismatch;
    logic             fault_n, brake_n, cut_n, torque_n;

    psc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_busy (r_out_valid && !o_out.ready),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    psc_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // 3*x0 + 2*x1 + x2
    assign sum_a_n = SUM_W'({i_in.throttle_a_sample, 1'b0}) + SUM_W'(i_in.throttle_a_sample)
                   + SUM_W'({r_ha0, 1'b0}) + SUM_W'(r_ha1);
    assign sum_b_n = SUM_W'({i_in.throttle_b_sample, 1'b0}) + SUM_W'(i_in.throttle_b_sample)
                   + SUM_W'({r_hb0, 1'b0}) + SUM_W'(r_hb1);
    assign sum_k_n = SUM_W'({i_in.brake_sample, 1'b0}) + SUM_W'(i_in.brake_sample)
                   + SUM_W'({r_hk0, 1'b0}) + SUM_W'(r_hk1);

    // clamps
    assign fa_x    = FW'(r_fa);
    assign fb_x    = FW'(r_fb);
    assign fk_x    = FW'(r_fk);
    assign a_clamp = (fa_x > FW'(psc_pkg::A_MAX)) ? psc_pkg::A_LEVEL_W'(psc_pkg::A_MAX) :
                     (fa_x > FW'(psc_pkg::A_MIN)) ? psc_pkg::A_LEVEL_W'(fa_x) :
                                                    psc_pkg::A_LEVEL_W'(psc_pkg::A_MIN);
    assign b_clamp = (fb_x > FW'(psc_pkg::B_MAX)) ? psc_pkg::B_MAX :
                     (fb_x > FW'(psc_pkg::B_MIN)) ? psc_pkg::LEVEL_W'(fb_x) : psc_pkg::B_MIN;
    assign k_lvl   = (fk_x > FW'(psc_pkg::BRAKE_MIN)) ? fk_x : FW'(psc_pkg::BRAKE_MIN);

    assign quad_t = psc_pkg::QT_W'(prod - P_W'(psc_pkg::K1));

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            psc_pkg::MUL_DIV_A: begin
                mul_a = MA_W'(r_sum_a);
                mul_b = MB_W'(RCP);
            end
            psc_pkg::MUL_DIV_B: begin
                mul_a = MA_W'(r_sum_b);
                mul_b = MB_W'(RCP);
            end
            psc_pkg::MUL_DIV_K: begin
                mul_a = MA_W'(r_sum_k);
                mul_b = MB_W'(RCP);
            end
            psc_pkg::MUL_LIN: begin
                mul_a = MA_W'(a_clamp);
                mul_b = MB_W'(psc_pkg::K2);
            end
            psc_pkg::MUL_SQ: begin
                mul_a = MA_W'(quad_t);
                mul_b = MB_W'(a_clamp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // reciprocal quotient with one correction step
    assign div_sum = ctrl.cap_a ? r_sum_a : (ctrl.cap_b ? r_sum_b : r_sum_k);
    assign q0      = prod[RCP_SH +: ADC_BITS];
    assign rem     = div_sum - (SUM_W'({q0, 2'b00}) + SUM_W'({q0, 1'b0}));
    assign quo     = (rem >= SUM_W'(6)) ? q0 + ADC_BITS'(1) : q0;

    // mismatch: 10*|f - b| > f, Q16
    assign f_val    = prod[F_W-1:0] + F_W'(psc_pkg::K0);
    assign d_raw    = {1'b0, f_val} - (F_W+1)'({b_clamp, {psc_pkg::Q_SHIFT{1'b0}}});
    assign d_abs    = d_raw[F_W] ? F_W'(-d_raw) : d_raw[F_W-1:0];
    assign d10      = D10_W'({d_abs, 3'b000}) + D10_W'({d_abs, 1'b0});
    assign mismatch = d10 > D10_W'(f_val);

    // flags
    assign fault_n  = r_fault || (fa_x > FW'(psc_pkg::A_FAULT)) || (fb_x > FW'(psc_pkg::B_FAULT))
                   || (r_last_brake > psc_pkg::BRAKE_FAULT);
    assign brake_n  = (k_lvl > FW'(r_brake_on)) ? 1'b1 :
                      ((k_lvl < FW'(r_brake_off)) && r_run) ? 1'b0 : r_brake;
    assign cut_n    = (b_clamp > r_torque_cut) && brake_n;
    assign torque_n = cut_n ? 1'b0 : ((b_clamp < r_torque_rearm) ? 1'b1 : r_torque);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake_on     <= psc_pkg::BRAKE_ON_RST;
            r_brake_off    <= psc_pkg::BRAKE_OFF_RST;
            r_torque_cut   <= psc_pkg::TORQUE_CUT_RST;
            r_torque_rearm <= psc_pkg::TORQUE_REARM_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                psc_pkg::CFG_BRAKE_ON:     r_brake_on     <= i_cfg.data;
                psc_pkg::CFG_BRAKE_OFF:    r_brake_off    <= i_cfg.data;
                psc_pkg::CFG_TORQUE_CUT:   r_torque_cut   <= i_cfg.data;
                psc_pkg::CFG_TORQUE_REARM: r_torque_rearm <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha0        <= '0;
            r_ha1        <= '0;
            r_hb0        <= '0;
            r_hb1        <= '0;
            r_hk0        <= '0;
            r_hk1        <= '0;
            r_last_brake <= '0;
            r_brake      <= 1'b0;
            r_torque     <= 1'b1;
            r_fault      <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                r_ha1 <= r_ha0;
                r_ha0 <= i_in.throttle_a_sample;
                r_hb1 <= r_hb0;
                r_hb0 <= i_in.throttle_b_sample;
                r_hk1 <= r_hk0;
                r_hk0 <= i_in.brake_sample;
            end
            if (ctrl.finish) begin
                r_last_brake <= k_lvl[psc_pkg::LEVEL_W-1:0];
                r_brake      <= brake_n;
                r_torque     <= torque_n;
                r_fault      <= fault_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_sum_a <= sum_a_n;
            r_sum_b <= sum_b_n;
            r_sum_k <= sum_k_n;
            r_run   <= i_in.run_permitted;
        end
        if (ctrl.cap_a) begin
            r_fa <= quo;
        end
        if (ctrl.cap_b) begin
            r_fb <= quo;
        end
        if (ctrl.cap_k) begin
            r_fk <= quo;
        end
        if (ctrl.finish) begin
            r_out_a      <= a_clamp;
            r_out_b      <= b_clamp;
            r_out_k      <= k_lvl[psc_pkg::LEVEL_W-1:0];
            r_out_brake  <= brake_n;
            r_out_torque <= torque_n;
            r_out_cut    <= cut_n;
            r_out_fault  <= fault_n;
            r_out_mis    <= mismatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.throttle_a_level = r_out_a;
    assign o_out.throttle_b_level = r_out_b;
    assign o_out.brake_level      = r_out_k;
    assign o_out.brake_pressed    = r_out_brake;
    assign o_out.torque_allowed   = r_out_torque;
    assign o_out.torque_cut_now   = r_out_cut;
    assign o_out.sensor_fault     = r_out_fault;
    assign o_out.sensor_mismatch  = r_out_mis;

    `PSC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, ctrl.accept, !in_ready, "accept did not start work")
    `PSC_ASSERT_NXT(a_no_spurious_out, i_clk, i_rst_n, (!r_out_valid && !ctrl.finish), !r_out_valid, "result without finish")
    `PSC_ASSERT_IMP(a_cut_disables, i_clk, i_rst_n, (r_out_valid && r_out_cut), (!r_out_torque && r_out_brake), "cut with torque or no brake")
    `PSC_ASSERT_IMP(a_a_range, i_clk, i_rst_n, r_out_valid, (r_out_a >= psc_pkg::A_LEVEL_W'(psc_pkg::A_MIN) && r_out_a <= psc_pkg::A_LEVEL_W'(psc_pkg::A_MAX)), "throttle A out of range")

endmodule

// File: rtl/core/psc_mul.sv
// Shared signed multiplier with registered product.
module psc_mul #(
    parameter int A_W = 20,
    parameter int B_W = 14
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/psc_seq.sv
// Sequencer stepping one sample set through the shared multiplier.
module psc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_busy,
    output logic               o_in_ready,
    output psc_pkg::t_seq_ctrl o_ctrl
);

    psc_pkg::t_state r_state;
    psc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_ctrl         = '0;
        o_ctrl.mul_sel = psc_pkg::MUL_DIV_A;
        case (r_state)
            psc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.accept = 1'b1;
                    n_state       = psc_pkg::ST_DIV_A;
                end
            end
            psc_pkg::ST_DIV_A: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = psc_pkg::MUL_DIV_A;
                n_state        = psc_pkg::ST_DIV_B;
            end
            psc_pkg::ST_DIV_B: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = psc_pkg::MUL_DIV_B;
                o_ctrl.cap_a   = 1'b1;
                n_state        = psc_pkg::ST_DIV_K;
            end
            psc_pkg::ST_DIV_K: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = psc_pkg::MUL_DIV_K;
                o_ctrl.cap_b   = 1'b1;
                n_state        = psc_pkg::ST_QUAD_LIN;
            end
            psc_pkg::ST_QUAD_LIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = psc_pkg::MUL_LIN;
                o_ctrl.cap_k   = 1'b1;
                n_state        = psc_pkg::ST_QUAD_SQ;
            end
            psc_pkg::ST_QUAD_SQ: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = psc_pkg::MUL_SQ;
                n_state        = psc_pkg::ST_FINISH;
            end
            psc_pkg::ST_FINISH: begin
                if (!i_out_busy) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = psc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
